>>> hw/rtl/lkst_pkg.sv
// Shared types and constants for the LRU key slot table.
// Holds request kinds, controller states and the table entry layout.
// No dependencies.
`timescale 1ns / 1ps

package lkst_pkg;

  localparam int unsigned KIND_W        = 2;
  localparam int unsigned KEY_W         = 64;
  localparam int unsigned STAMP_W       = 64;
  localparam int unsigned SLOT_W        = 8;
  localparam int unsigned OCC_W         = 9;
  localparam int unsigned DEFAULT_DEPTH = 256;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DROP   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DROP_RD,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

>>> hw/rtl/lkst_req_if.sv
// Request channel of the LRU key slot table: valid/ready plus request fields.
// Depends on lkst_pkg for field widths.
`timescale 1ns / 1ps

interface lkst_req_if;
  logic                        valid;
  logic                        ready;
  logic [lkst_pkg::KIND_W-1:0] kind;
  logic [lkst_pkg::KEY_W-1:0]  key;
  logic [lkst_pkg::SLOT_W-1:0] slot_index;

  modport source (output valid, output kind, output key, output slot_index, input ready);
  modport sink   (input valid, input kind, input key, input slot_index, output ready);
endinterface

>>> hw/rtl/lkst_rsp_if.sv
// Result channel of the LRU key slot table: valid/ready plus result fields.
// Depends on lkst_pkg for field widths.
`timescale 1ns / 1ps

interface lkst_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [lkst_pkg::SLOT_W-1:0] slot;
  logic                        evicted;
  logic [lkst_pkg::KEY_W-1:0]  evicted_key;
  logic [lkst_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, output hit, output slot, output evicted, output evicted_key,
                  output occupancy, input ready);
  modport sink   (input valid, input hit, input slot, input evicted, input evicted_key,
                  input occupancy, output ready);
endinterface

>>> hw/rtl/lru_key_slot_table_core.sv
// Fully associative key table with LRU replacement, built around one entry memory.
// Depends on lkst_pkg, lkst_req_if and lkst_rsp_if.
`timescale 1ns / 1ps

// The table keeps TABLE_DEPTH entries of {valid, key, stamp} in a single
// synchronous memory with one read and one write port, and handles one request
// at a time. Lookup and insert walk the entries below the high-water mark, one
// memory read per cycle; a lookup or insert that finds its key in slot n stops
// the walk there. A drop of a slot below the high-water mark reads the entry,
// then, if it was valid, writes it back as invalid; any other drop, and a clear,
// goes straight to the update. Every request also waits to finish while the
// previous result is still held in the output register. No clearing pass follows
// reset or clear: entries at or above the high-water mark are never read before
// they are written. The result sits in an output register, so the next request
// is taken while an earlier result still waits.

module lru_key_slot_table_core #(
  parameter int unsigned TABLE_DEPTH = lkst_pkg::DEFAULT_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  lkst_req_if.sink  req,
  lkst_rsp_if.source rsp
);
  import lkst_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // entry memory
  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;
  logic   rd_en;
  logic [IW-1:0] rd_addr;
  logic   wr_en;
  logic [IW-1:0] wr_addr;
  entry_t wr_data;

  // controller
  state_t state, state_next;
  logic   accept;
  logic   finish;
  logic   out_free;

  // latched request
  kind_t              op_kind;
  logic [KEY_W-1:0]   op_key;
  logic [SLOT_W-1:0]  op_slot;
  logic               drop_ok;

  // table bookkeeping
  logic [CW-1:0]      hw, hw_next;
  logic [CW-1:0]      occ, occ_next;
  logic [STAMP_W-1:0] use_clock, clock_next;
  logic [STAMP_W-1:0] stamp_new;

  // scan
  logic [CW-1:0]      issue_idx;
  logic               issue_more;
  logic               rd_ok;
  logic [IW-1:0]      rd_idx;
  logic               scan_hit;
  logic               match_found;
  logic [IW-1:0]      match_idx;
  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic               min_found;
  logic [IW-1:0]      min_idx;
  logic [STAMP_W-1:0] min_stamp;
  logic [KEY_W-1:0]   min_key;

  // result
  logic               upd_wr_en;
  logic               res_hit;
  logic [SLOT_W-1:0]  res_slot;
  logic               res_evicted;
  logic [KEY_W-1:0]   res_ekey;
  logic               out_valid;
  logic               out_hit;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_evicted;
  logic [KEY_W-1:0]   out_ekey;
  logic [OCC_W-1:0]   out_occ;

  logic               req_in_range;

  assign req.ready    = (state == ST_IDLE);
  assign out_free     = !out_valid || rsp.ready;
  assign issue_more   = (issue_idx < hw);
  assign scan_hit     = rd_ok && rd_data.valid && (rd_data.key == op_key);
  assign stamp_new    = use_clock + STAMP_W'(1);
  assign req_in_range = (DW'(req.slot_index) < DW'(hw));

  // next state and control strobes
  always_comb begin
    state_next = state;
    accept     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = issue_idx[IW-1:0];
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          accept = 1'b1;
          case (kind_t'(req.kind))
            KIND_LOOKUP, KIND_INSERT: state_next = ST_SCAN;
            KIND_DROP:                state_next = req_in_range ? ST_DROP_RD : ST_UPDATE;
            default:                  state_next = ST_UPDATE;
          endcase
        end
      end
      ST_SCAN: begin
        rd_en = issue_more && !scan_hit;
        if (scan_hit || (!rd_ok && !issue_more)) begin
          state_next = ST_UPDATE;
        end
      end
      ST_DROP_RD: begin
        rd_en      = 1'b1;
        rd_addr    = IW'(op_slot);
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // latch the request
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= kind_t'(req.kind);
      op_key  <= req.key;
      op_slot <= req.slot_index;
      drop_ok <= req_in_range;
    end
  end

  // walk the entries: track first match, first free slot and oldest stamp
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok       <= 1'b0;
      issue_idx   <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      min_found   <= 1'b0;
    end else begin
      rd_ok <= rd_en && (state == ST_SCAN);
      if (accept) begin
        issue_idx   <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
        min_found   <= 1'b0;
      end else if (state == ST_SCAN) begin
        if (rd_en) begin
          issue_idx <= issue_idx + CW'(1);
        end
        if (rd_ok) begin
          if (scan_hit) begin
            match_found <= 1'b1;
          end
          if (!rd_data.valid && !free_found) begin
            free_found <= 1'b1;
          end
          if (rd_data.valid && (!min_found || rd_data.stamp < min_stamp)) begin
            min_found <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= issue_idx[IW-1:0];
    if (state == ST_SCAN && rd_ok) begin
      if (scan_hit) begin
        match_idx <= rd_idx;
      end
      if (!rd_data.valid && !free_found) begin
        free_idx <= rd_idx;
      end
      if (rd_data.valid && (!min_found || rd_data.stamp < min_stamp)) begin
        min_idx   <= rd_idx;
        min_stamp <= rd_data.stamp;
        min_key   <= rd_data.key;
      end
    end
  end

  // decide the write-back and the result
  always_comb begin
    upd_wr_en   = 1'b0;
    wr_addr     = match_idx;
    wr_data     = '{valid: 1'b1, key: op_key, stamp: stamp_new};
    res_hit     = 1'b0;
    res_slot    = '0;
    res_evicted = 1'b0;
    res_ekey    = '0;
    hw_next     = hw;
    occ_next    = occ;
    clock_next  = use_clock;
    case (op_kind)
      KIND_LOOKUP: begin
        if (match_found) begin
          upd_wr_en  = 1'b1;
          res_hit    = 1'b1;
          res_slot   = SLOT_W'(match_idx);
          clock_next = stamp_new;
        end
      end
      KIND_INSERT: begin
        upd_wr_en  = 1'b1;
        clock_next = stamp_new;
        if (match_found) begin
          res_hit = 1'b1;
        end else if (free_found) begin
          wr_addr  = free_idx;
          occ_next = occ + CW'(1);
        end else if (hw < DEPTH_C) begin
          wr_addr  = IW'(hw);
          hw_next  = hw + CW'(1);
          occ_next = occ + CW'(1);
        end else begin
          wr_addr     = min_idx;
          res_evicted = 1'b1;
          res_ekey    = min_key;
        end
        res_slot = SLOT_W'(wr_addr);
      end
      KIND_DROP: begin
        res_slot = op_slot;
        wr_addr  = IW'(op_slot);
        wr_data  = '{valid: 1'b0, key: rd_data.key, stamp: rd_data.stamp};
        if (drop_ok && rd_data.valid) begin
          upd_wr_en = 1'b1;
          occ_next  = occ - CW'(1);
        end
      end
      default: begin
        hw_next  = '0;
        occ_next = '0;
      end
    endcase
  end

  assign wr_en = finish && upd_wr_en;

  // commit bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      hw        <= '0;
      occ       <= '0;
      use_clock <= '0;
    end else if (finish) begin
      hw        <= hw_next;
      occ       <= occ_next;
      use_clock <= clock_next;
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_hit     <= res_hit;
      out_slot    <= res_slot;
      out_evicted <= res_evicted;
      out_ekey    <= res_ekey;
      out_occ     <= OCC_W'(occ_next);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.hit         = out_hit;
  assign rsp.slot        = out_slot;
  assign rsp.evicted     = out_evicted;
  assign rsp.evicted_key = out_ekey;
  assign rsp.occupancy   = out_occ;

endmodule

>>> hw/rtl/lkst_checker.sv
// Port-level checks for the LRU key slot table, bound to its top level.
// Depends on lkst_pkg and lru_key_slot_table_core.
`timescale 1ns / 1ps

module lkst_checker #(
  parameter int unsigned TABLE_DEPTH = lkst_pkg::DEFAULT_DEPTH
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        rsp_hit,
  input logic [lkst_pkg::SLOT_W-1:0] rsp_slot,
  input logic                        rsp_evicted,
  input logic [lkst_pkg::KEY_W-1:0]  rsp_evicted_key,
  input logic [lkst_pkg::OCC_W-1:0]  rsp_occupancy
);
  import lkst_pkg::*;

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its fields
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      $stable({rsp_hit, rsp_slot, rsp_evicted, rsp_evicted_key, rsp_occupancy}))
    else $error("result fields changed while stalled");

  // one request at a time: ready drops after each accepted request
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  // eviction only from a full table, never together with a hit
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_evicted |-> !rsp_hit && (rsp_occupancy == OCC_W'(TABLE_DEPTH)))
    else $error("eviction reported without a full table");

  // evicted key is zero unless an entry was evicted
  a_ekey_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_evicted |-> (rsp_evicted_key == '0))
    else $error("evicted key set without an eviction");

endmodule

bind lru_key_slot_table_core lkst_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_lkst_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_hit         (rsp.hit),
  .rsp_slot        (rsp.slot),
  .rsp_evicted     (rsp.evicted),
  .rsp_evicted_key (rsp.evicted_key),
  .rsp_occupancy   (rsp.occupancy)
);

>>> bench/tb_lru_key_slot_table_core.sv
// Testbench for lru_key_slot_table_core: random and directed requests, LRU prediction, checking.
// Depends on lkst_pkg, lkst_req_if, lkst_rsp_if and the core itself.
`timescale 1ns / 1ps

module tb_lru_key_slot_table_core;

  import lkst_pkg::*;

  localparam int unsigned TABLE_DEPTH    = DEFAULT_DEPTH;
  localparam int          MAX_REPORTS    = 10;
  localparam int          RANDOM_ITEMS   = 280;
  localparam int          LONG_HOLD      = 400;
  localparam int          DRAIN_CYCLES   = TABLE_DEPTH + 16;
  localparam int          KNOWN_KEYS_CAP = 300;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    logic [OCC_W-1:0]  occupancy;
  } table_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lkst_req_if req_bus ();
  lkst_rsp_if rsp_bus ();

  lru_key_slot_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  // Mirror of the table contents used for prediction
  logic                mirror_valid [TABLE_DEPTH];
  logic [KEY_W-1:0]    mirror_key   [TABLE_DEPTH];
  logic [STAMP_W-1:0]  mirror_stamp [TABLE_DEPTH];
  int                  mirror_high;
  logic [STAMP_W-1:0]  mirror_clock;

  table_result_t       awaited_results [$];
  logic [KEY_W-1:0]    known_keys [$];
  int                  fail_count;
  bit                  steady;
  bit                  hold_go;
  bit                  hold_on;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int draw_gap();
    return steady ? 0 : int'($urandom_range(0, 6));
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    return {$urandom, $urandom};
  endfunction

  function automatic int find_mirror_key(logic [KEY_W-1:0] key);
    int i;
    for (i = 0; i < mirror_high; i++) begin
      if (mirror_valid[i] && mirror_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one request to the mirror and return the result it should produce
  function automatic table_result_t compute_table_result(kind_t kind, logic [KEY_W-1:0] key,
                                                         logic [SLOT_W-1:0] idx);
    table_result_t res;
    int            pick;
    int            i;
    bit            have;
    int            occ;
    res = '0;
    case (kind)
      KIND_LOOKUP: begin
        pick = find_mirror_key(key);
        if (pick >= 0) begin
          mirror_clock       = mirror_clock + 1'b1;
          mirror_stamp[pick] = mirror_clock;
          res.hit            = 1'b1;
          res.slot           = SLOT_W'(pick);
        end
      end
      KIND_INSERT: begin
        pick    = find_mirror_key(key);
        have    = (pick >= 0);
        res.hit = have;
        // prefer the first free slot below the high-water mark
        for (i = 0; !have && i < mirror_high; i++) begin
          if (!mirror_valid[i]) begin
            pick = i;
            have = 1'b1;
          end
        end
        if (!have && mirror_high < TABLE_DEPTH) begin
          pick = mirror_high;
          mirror_high++;
          have = 1'b1;
        end
        // table full: evict the oldest stamp, lowest slot on a tie
        if (!have) begin
          pick = -1;
          for (i = 0; i < mirror_high; i++) begin
            if (mirror_valid[i] && (pick < 0 || mirror_stamp[i] < mirror_stamp[pick])) pick = i;
          end
          res.evicted     = 1'b1;
          res.evicted_key = mirror_key[pick];
        end
        mirror_valid[pick] = 1'b1;
        mirror_key[pick]   = key;
        mirror_clock       = mirror_clock + 1'b1;
        mirror_stamp[pick] = mirror_clock;
        res.slot           = SLOT_W'(pick);
      end
      KIND_DROP: begin
        res.slot = idx;
        if (int'(idx) < mirror_high) mirror_valid[idx] = 1'b0;
      end
      default: begin
        for (i = 0; i < TABLE_DEPTH; i++) mirror_valid[i] = 1'b0;
        mirror_high = 0;
      end
    endcase
    occ = 0;
    for (i = 0; i < mirror_high; i++) begin
      if (mirror_valid[i]) occ++;
    end
    res.occupancy = OCC_W'(occ);
    return res;
  endfunction

  // Offer one request after a random gap; keep valid high if the gap is zero
  task automatic send_request(kind_t kind, logic [KEY_W-1:0] key, logic [SLOT_W-1:0] idx);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.kind       <= kind;
    req_bus.key        <= key;
    req_bus.slot_index <= idx;
    do @(posedge clk); while (!req_bus.ready);
    awaited_results.push_back(compute_table_result(kind, key, idx));
  endtask

  task automatic insert_fresh(output logic [KEY_W-1:0] key);
    key = fresh_key();
    known_keys.push_back(key);
    if (known_keys.size() > KNOWN_KEYS_CAP) void'(known_keys.pop_front());
    send_request(KIND_INSERT, key, SLOT_W'($urandom_range(0, 255)));
  endtask

  task automatic test_directed_requests();
    logic [KEY_W-1:0] ones;
    logic [KEY_W-1:0] spare;
    ones = '1;
    send_request(KIND_LOOKUP, '0, 8'd0);                    // miss in an empty table
    send_request(KIND_INSERT, '0, 8'd255);
    send_request(KIND_INSERT, ones, 8'd0);
    send_request(KIND_INSERT, 64'h8000_0000_0000_0001, 8'd0);
    send_request(KIND_INSERT, '0, 8'd0);                    // same key: replace in place
    send_request(KIND_LOOKUP, ones, 8'd0);
    send_request(KIND_LOOKUP, 64'h0000_0000_0000_1234, 8'd0);
    send_request(KIND_DROP, '0, 8'd0);
    send_request(KIND_DROP, '0, 8'd0);                      // free slot stays free
    send_request(KIND_DROP, '0, 8'd255);                    // above the high-water mark
    send_request(KIND_LOOKUP, '0, 8'd0);                    // dropped key no longer found
    send_request(KIND_INSERT, 64'h5555_5555_5555_5555, 8'd0);
    send_request(KIND_DROP, '0, 8'd2);
    send_request(KIND_DROP, '0, 8'd1);
    spare = fresh_key();
    send_request(KIND_INSERT, spare, 8'd0);                 // takes the lowest free slot
    send_request(KIND_CLEAR, ones, 8'd255);
    send_request(KIND_LOOKUP, ones, 8'd0);
    send_request(KIND_DROP, '0, 8'd0);                      // nothing below the mark
    send_request(KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 8'd0);
    send_request(KIND_INSERT, ones, 8'd0);
    send_request(KIND_CLEAR, '0, 8'd0);
  endtask

  task automatic test_fill_and_evict();
    logic [KEY_W-1:0] fill_keys [TABLE_DEPTH];
    logic [KEY_W-1:0] key;
    int               i;
    send_request(KIND_CLEAR, '0, 8'd0);
    for (i = 0; i < TABLE_DEPTH; i++) begin
      insert_fresh(key);
      fill_keys[i] = key;
    end
    // touch the oldest entries so the next ones in line become least recent
    for (i = 0; i < 20; i++) send_request(KIND_LOOKUP, fill_keys[i], 8'd0);
    for (i = 0; i < 30; i++) insert_fresh(key);
    send_request(KIND_LOOKUP, fill_keys[20], 8'd0);
    send_request(KIND_INSERT, fill_keys[5], 8'd0);
    // freed slots are reused before anything is evicted
    for (i = 0; i < 3; i++) send_request(KIND_DROP, '0, SLOT_W'($urandom_range(0, 255)));
    for (i = 0; i < 4; i++) insert_fresh(key);
  endtask

  task automatic test_output_backpressure();
    logic [KEY_W-1:0] key;
    int               i;
    steady  = 1'b1;
    hold_go = 1'b1;
    for (i = 0; i < 12; i++) begin
      if (i % 3 == 0) send_request(KIND_LOOKUP, known_keys[$urandom_range(0, known_keys.size() - 1)],
                                   8'd0);
      else insert_fresh(key);
    end
    steady = 1'b0;
  endtask

  task automatic test_random_mix();
    int               n;
    int               roll;
    kind_t            kind;
    logic [KEY_W-1:0] key;
    logic [SLOT_W-1:0] idx;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // alternate idle and back-to-back stretches
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      idx  = SLOT_W'($urandom_range(0, 255));
      key  = fresh_key();
      if (roll < 35) begin
        kind = KIND_LOOKUP;
        if (known_keys.size() != 0 && $urandom_range(0, 4) != 0)
          key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else if (roll < 80) begin
        kind = KIND_INSERT;
        if (known_keys.size() != 0 && $urandom_range(0, 3) == 0)
          key = known_keys[$urandom_range(0, known_keys.size() - 1)];
        else begin
          known_keys.push_back(key);
          if (known_keys.size() > KNOWN_KEYS_CAP) void'(known_keys.pop_front());
        end
      end else if (roll < 98) begin
        kind = KIND_DROP;
        if (mirror_high != 0 && $urandom_range(0, 3) != 0)
          idx = SLOT_W'($urandom_range(0, mirror_high - 1));
      end else begin
        kind = KIND_CLEAR;
      end
      send_request(kind, key, idx);
    end
    steady = 1'b0;
  endtask

  // Hold the result side off for a long stretch once asked
  initial begin : result_hold
    hold_on = 1'b0;
    wait (hold_go);
    hold_on = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_on = 1'b0;
  end

  // Accept results with random stalls and compare each with the oldest prediction
  initial begin : result_checker
    table_result_t want;
    table_result_t seen;
    string         bad;
    int            stall;
    rsp_bus.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall != 0 || hold_on) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_on) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
      seen.hit         = rsp_bus.hit;
      seen.slot        = rsp_bus.slot;
      seen.evicted     = rsp_bus.evicted;
      seen.evicted_key = rsp_bus.evicted_key;
      seen.occupancy   = rsp_bus.occupancy;
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: hit=%0b slot=%0d evicted=%0b evicted_key=%h occupancy=%0d",
                   seen.hit, seen.slot, seen.evicted, seen.evicted_key, seen.occupancy);
      end else begin
        want = awaited_results.pop_front();
        bad  = "";
        if (seen.hit !== want.hit) bad = {bad, " hit"};
        if (seen.slot !== want.slot) bad = {bad, " slot"};
        if (seen.evicted !== want.evicted) bad = {bad, " evicted"};
        if (seen.evicted_key !== want.evicted_key) bad = {bad, " evicted_key"};
        if (seen.occupancy !== want.occupancy) bad = {bad, " occupancy"};
        if (bad != "") begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("mismatch at %0t on%s", $realtime, bad);
            $display("  expected hit=%0b slot=%0d evicted=%0b evicted_key=%h occupancy=%0d",
                     want.hit, want.slot, want.evicted, want.evicted_key, want.occupancy);
            $display("  actual   hit=%0b slot=%0d evicted=%0b evicted_key=%h occupancy=%0d",
                     seen.hit, seen.slot, seen.evicted, seen.evicted_key, seen.occupancy);
          end
        end
      end
    end
  end

  // Abandon a run that hangs
  initial begin : run_limit
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : test_sequence
    int i;
    fail_count   = 0;
    steady       = 1'b0;
    mirror_high  = 0;
    mirror_clock = '0;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      mirror_valid[i] = 1'b0;
      mirror_key[i]   = '0;
      mirror_stamp[i] = '0;
    end
    req_bus.valid      <= 1'b0;
    req_bus.kind       <= KIND_LOOKUP;
    req_bus.key        <= '0;
    req_bus.slot_index <= '0;
    rst                <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_requests();
    test_fill_and_evict();
    test_output_backpressure();
    test_random_mix();

    // drain outstanding results, then watch for stray ones
    req_bus.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/lkst_pkg.sv
hw/rtl/lkst_req_if.sv
hw/rtl/lkst_rsp_if.sv
hw/rtl/lru_key_slot_table_core.sv
hw/rtl/lkst_checker.sv
bench/tb_lru_key_slot_table_core.sv
